>>> design/bse_pkg.sv
// Package for the bucket sort engine.
// It holds the sizes, widths and controller state type shared by the design.
// It has no dependencies.
package bse_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 16;
  localparam int ADDR_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } bse_state_e;

endpackage

>>> design/bucket_sort_engine_unit.sv
// Top level of the bucket sort engine: the sorted store and its controller.
// It depends on bse_pkg.
//
// A batch of unsigned values streams in, one item per accepted beat, and the
// beat with tlast closes it. Each value is placed in order as it arrives, by
// moving the larger stored values up one place at a time through a store
// with one read and one write port and a registered read. Each stored value
// greater than an item moves up one place, and the item is then written
// into the freed place; the first item of a batch and a dropped item need no
// compare. Once the batch is closed, the values leave in ascending order.
// For each output item, a store read is followed by a load of the output
// register, and the item is offered until taken. The final output item
// carries tlast. Up to MAX_ITEMS values are kept. Further values are
// dropped, and tuser is then set on every output item of that batch. No
// input item is taken while an insertion or the readout is under way.
module bucket_sort_engine_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bse_pkg::VALUE_WIDTH-1:0] s_axis_tdata_i,  // value
  input  logic                         s_axis_tlast_i,     // last
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bse_pkg::VALUE_WIDTH-1:0] m_axis_tdata_o,  // sorted_value
  output logic                         m_axis_tlast_o,     // last_out
  output logic                         m_axis_tuser_o      // overflowed
);
  import bse_pkg::*;

  logic [VALUE_WIDTH-1:0] mem_q [MAX_ITEMS];

  bse_state_e             state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;
  logic                   last_q, last_d;
  logic                   ovf_q, ovf_d;
  logic [VALUE_WIDTH-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;
  logic [VALUE_WIDTH-1:0] rdata_q;

  logic [ADDR_W-1:0]      raddr;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic                   in_acc;
  logic                   finish;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    key_d      = key_q;
    last_d     = last_q;
    ovf_d      = ovf_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    raddr      = pos_q[ADDR_W-1:0];
    we         = 1'b0;
    waddr      = pos_q[ADDR_W-1:0];
    wdata      = key_q;
    finish     = 1'b0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (in_acc) begin
          key_d  = s_axis_tdata_i;
          last_d = s_axis_tlast_i;
          if (count_q == CNT_W'(MAX_ITEMS)) begin
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              pos_d   = '0;
              state_d = ST_EMIT_RD;
            end
          end else if (count_q == '0) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = s_axis_tdata_i;
            count_d = CNT_W'(1);
            if (s_axis_tlast_i) begin
              pos_d   = '0;
              state_d = ST_EMIT_RD;
            end
          end else begin
            pos_d   = count_q;
            raddr   = ADDR_W'(count_q - CNT_W'(1));
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (rdata_q > key_q) begin
          we    = 1'b1;
          wdata = rdata_q;
          pos_d = pos_q - CNT_W'(1);
          if (pos_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            raddr = ADDR_W'(pos_q - CNT_W'(2));
          end
        end else begin
          we     = 1'b1;
          finish = 1'b1;
        end
      end
      ST_PLACE: begin
        we     = 1'b1;
        finish = 1'b1;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_data_d = rdata_q;
        out_last_d = (pos_q + CNT_W'(1)) == count_q;
        state_d    = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        m_axis_tvalid_o = 1'b1;
        if (m_axis_tready_i) begin
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            pos_d   = pos_q + CNT_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
    if (finish) begin
      count_d = count_q + CNT_W'(1);
      if (last_q) begin
        pos_d   = '0;
        state_d = ST_EMIT_RD;
      end else begin
        state_d = ST_LOAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign m_axis_tdata_o = out_data_q;
  assign m_axis_tlast_o = out_last_q;
  assign m_axis_tuser_o = ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("Stored count exceeds the store capacity.");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("Input taken while an output item is offered.");

  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
      (count_q == '0 && !ovf_q))
    else $error("Batch state not cleared after the final output item.");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (count_q != '0 && pos_q < count_q))
    else $error("Output item offered outside the stored batch.");

endmodule
